// ----- hdl/cc20_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types and constants for the ChaCha20 stream cipher block.
// ----------------------------------------------------------------------------
package cc20_pkg;

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    localparam logic [2:0] REG_KEY_PART_0     = 3'd0;
    localparam logic [2:0] REG_KEY_PART_1     = 3'd1;
    localparam logic [2:0] REG_KEY_PART_2     = 3'd2;
    localparam logic [2:0] REG_KEY_PART_3     = 3'd3;
    localparam logic [2:0] REG_NONCE_LOW      = 3'd4;
    localparam logic [2:0] REG_NONCE_HIGH     = 3'd5;
    localparam logic [2:0] REG_INITIAL_COUNTER = 3'd6;

    localparam logic [31:0] INITIAL_COUNTER_RESET = 32'd1;

    typedef logic [15:0][31:0] cc20_block_t;

    typedef struct packed {
        logic [63:0] key_part_0;
        logic [63:0] key_part_1;
        logic [63:0] key_part_2;
        logic [63:0] key_part_3;
        logic [63:0] nonce_low;
        logic [31:0] nonce_high;
        logic [31:0] initial_counter;
    } cc20_cfg_t;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b000_0001,
        S_LOAD   = 7'b000_0010,
        S_ROUND  = 7'b000_0100,
        S_DIAG   = 7'b000_1000,
        S_UNDIAG = 7'b001_0000,
        S_FEED   = 7'b010_0000,
        S_EMIT   = 7'b100_0000
    } cc20_state_t;

endpackage
`default_nettype wire

// ----- hdl/cc20_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_core
// Keystream sequencer: one add/xor/rotate unit on fixed state taps, row
// rotations bring each column under it, then a serial feed-forward add.
// ----------------------------------------------------------------------------
module cc20_core #(
    parameter int ROUND_COUNT = 20
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  cc20_pkg::cc20_cfg_t cfg,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [7:0]          plain_byte,
    input  wire                 end_of_message,
    input  wire                 restart,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [7:0]          cipher_byte
);
    import cc20_pkg::*;

    localparam int DR  = (ROUND_COUNT + 1) / 2;
    localparam int DRW = $clog2(DR + 1);

    cc20_state_t      state_reg, state_next;
    cc20_block_t      x_reg, x_next;
    cc20_block_t      init_w, upd, x_rot, x_diag, x_undiag, x_shift;
    logic [1:0]       op_reg, op_next;
    logic [1:0]       q_reg, q_next;
    logic             half_reg, half_next;
    logic [DRW-1:0]   dr_reg, dr_next;
    logic [3:0]       ff_reg, ff_next;
    logic [5:0]       pos_reg, pos_next;
    logic             ksv_reg, ksv_next;
    logic [31:0]      ctr_reg, ctr_next;
    logic             ov_reg, ov_next;
    logic [7:0]       cb_reg, cb_next;
    logic [7:0]       pb_reg, pb_next;
    logic             eom_reg, eom_next;
    logic [31:0]      op_a, op_b, sum, mix, rot;
    logic [31:0]      ks_word, ks_shift;

    always_comb
    begin
        init_w[0]  = SIGMA_0;
        init_w[1]  = SIGMA_1;
        init_w[2]  = SIGMA_2;
        init_w[3]  = SIGMA_3;
        init_w[4]  = cfg.key_part_0[31:0];
        init_w[5]  = cfg.key_part_0[63:32];
        init_w[6]  = cfg.key_part_1[31:0];
        init_w[7]  = cfg.key_part_1[63:32];
        init_w[8]  = cfg.key_part_2[31:0];
        init_w[9]  = cfg.key_part_2[63:32];
        init_w[10] = cfg.key_part_3[31:0];
        init_w[11] = cfg.key_part_3[63:32];
        init_w[12] = ctr_reg;
        init_w[13] = cfg.nonce_low[31:0];
        init_w[14] = cfg.nonce_low[63:32];
        init_w[15] = cfg.nonce_high;
    end

    // shared unit: add, xor, rotate
    always_comb
    begin
        if (state_reg == S_FEED)
        begin
            op_a = x_reg[0];
            op_b = init_w[ff_reg];
        end
        else
        begin
            op_a = op_reg[0] ? x_reg[8]  : x_reg[0];
            op_b = op_reg[0] ? x_reg[12] : x_reg[4];
        end
        sum = op_a + op_b;
        mix = (op_reg[0] ? x_reg[4] : x_reg[12]) ^ sum;
        case (op_reg)
            2'd0:    rot = {mix[15:0], mix[31:16]};
            2'd1:    rot = {mix[19:0], mix[31:20]};
            2'd2:    rot = {mix[23:0], mix[31:24]};
            default: rot = {mix[24:0], mix[31:25]};
        endcase
    end

    always_comb
    begin
        upd = x_reg;
        if (op_reg[0])
        begin
            upd[8] = sum;
            upd[4] = rot;
        end
        else
        begin
            upd[0]  = sum;
            upd[12] = rot;
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                x_rot[r*4 + c]    = upd[r*4 + ((c + 1) & 3)];
                x_diag[r*4 + c]   = x_reg[r*4 + ((c + r) & 3)];
                x_undiag[r*4 + c] = x_reg[r*4 + ((c + 4 - r) & 3)];
            end
        end
        for (int j = 0; j < 15; j++)
        begin
            x_shift[j] = x_reg[j + 1];
        end
        x_shift[15] = sum;
    end

    always_comb
    begin
        ks_word  = x_reg[pos_reg[5:2]];
        ks_shift = ks_word >> {pos_reg[1:0], 3'b000};
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        op_next    = op_reg;
        q_next     = q_reg;
        half_next  = half_reg;
        dr_next    = dr_reg;
        ff_next    = ff_reg;
        pos_next   = pos_reg;
        ksv_next   = ksv_reg;
        ctr_next   = ctr_reg;
        ov_next    = ov_reg && !out_ready;
        cb_next    = cb_reg;
        pb_next    = pb_reg;
        eom_next   = eom_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pb_next  = plain_byte;
                    eom_next = end_of_message;
                    if (restart)
                    begin
                        ctr_next   = cfg.initial_counter;
                        ksv_next   = 1'b0;
                        pos_next   = 6'd0;
                        state_next = S_LOAD;
                    end
                    else if (!ksv_reg)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_LOAD:
            begin
                x_next     = init_w;
                op_next    = 2'd0;
                q_next     = 2'd0;
                half_next  = 1'b0;
                dr_next    = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (op_reg != 2'd3)
                begin
                    x_next  = upd;
                    op_next = op_reg + 2'd1;
                end
                else
                begin
                    x_next  = x_rot;
                    op_next = 2'd0;
                    q_next  = q_reg + 2'd1;
                    if (q_reg == 2'd3)
                    begin
                        state_next = half_reg ? S_UNDIAG : S_DIAG;
                    end
                end
            end
            S_DIAG:
            begin
                x_next     = x_diag;
                half_next  = 1'b1;
                state_next = S_ROUND;
            end
            S_UNDIAG:
            begin
                x_next    = x_undiag;
                half_next = 1'b0;
                if (dr_reg == DRW'(DR - 1))
                begin
                    ff_next    = 4'd0;
                    state_next = S_FEED;
                end
                else
                begin
                    dr_next    = dr_reg + DRW'(1);
                    state_next = S_ROUND;
                end
            end
            S_FEED:
            begin
                x_next  = x_shift;
                ff_next = ff_reg + 4'd1;
                if (ff_reg == 4'd15)
                begin
                    ksv_next   = 1'b1;
                    pos_next   = 6'd0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cb_next = pb_reg ^ ks_shift[7:0];
                    ov_next = 1'b1;
                    if (pos_reg == 6'd63 || eom_reg)
                    begin
                        pos_next = 6'd0;
                        ksv_next = 1'b0;
                        ctr_next = ctr_reg + 32'd1;
                    end
                    else
                    begin
                        pos_next = pos_reg + 6'd1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= 2'd0;
            q_reg     <= 2'd0;
            half_reg  <= 1'b0;
            dr_reg    <= '0;
            ff_reg    <= 4'd0;
            pos_reg   <= 6'd0;
            ksv_reg   <= 1'b0;
            ctr_reg   <= INITIAL_COUNTER_RESET;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            q_reg     <= q_next;
            half_reg  <= half_next;
            dr_reg    <= dr_next;
            ff_reg    <= ff_next;
            pos_reg   <= pos_next;
            ksv_reg   <= ksv_next;
            ctr_reg   <= ctr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        cb_reg  <= cb_next;
        pb_reg  <= pb_next;
        eom_reg <= eom_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = ov_reg;
    assign cipher_byte = cb_reg;

    a_ksv_from_feed: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ksv_reg) |-> $past(state_reg == S_FEED))
        else $error("keystream marked valid outside feed-forward");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_EMIT))
        else $error("output word raised outside emit");

    a_ctr_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(ctr_reg) |-> $past(state_reg == S_EMIT
            || (state_reg == S_IDLE && in_valid && restart)))
        else $error("block counter changed unexpectedly");

    a_pos_needs_block: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != 6'd0) |-> ksv_reg)
        else $error("byte position set without a held block");

endmodule
`default_nettype wire

// ----- hdl/chacha20_stream_cipher_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top
// ChaCha20 (96-bit nonce) byte stream cipher with an APB register port.
// ----------------------------------------------------------------------------
// Channel  Signals                                      Direction
// in       in_valid/in_ready, plain_byte, end_of_message, restart   sink
// out      out_valid/out_ready, cipher_byte                          source
// cfg      psel, penable, pwrite, paddr, pwdata, prdata, pready      APB slave
//
// A byte from a held keystream block passes accept, then emit. A byte that
// needs a new block also passes load, the round, diagonal and undiagonal steps
// and the serial feed-forward, all on the single quarter-round step unit.
// in_ready is low from accept until the word is placed in the output register;
// a full output register stalls only the emit step.
// Reset is asynchronous; config registers return to zero, initial counter to 1.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_top #(
    parameter int ROUND_COUNT = 20
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [5:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [7:0]  plain_byte,
    input  wire         end_of_message,
    input  wire         restart,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [7:0]  cipher_byte
);
    import cc20_pkg::*;

    cc20_cfg_t  cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_part_0      <= 64'd0;
            cfg_reg.key_part_1      <= 64'd0;
            cfg_reg.key_part_2      <= 64'd0;
            cfg_reg.key_part_3      <= 64'd0;
            cfg_reg.nonce_low       <= 64'd0;
            cfg_reg.nonce_high      <= 32'd0;
            cfg_reg.initial_counter <= INITIAL_COUNTER_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_KEY_PART_0:      cfg_reg.key_part_0      <= pwdata;
                REG_KEY_PART_1:      cfg_reg.key_part_1      <= pwdata;
                REG_KEY_PART_2:      cfg_reg.key_part_2      <= pwdata;
                REG_KEY_PART_3:      cfg_reg.key_part_3      <= pwdata;
                REG_NONCE_LOW:       cfg_reg.nonce_low       <= pwdata;
                REG_NONCE_HIGH:      cfg_reg.nonce_high      <= pwdata[31:0];
                REG_INITIAL_COUNTER: cfg_reg.initial_counter <= pwdata[31:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KEY_PART_0:      prdata = cfg_reg.key_part_0;
            REG_KEY_PART_1:      prdata = cfg_reg.key_part_1;
            REG_KEY_PART_2:      prdata = cfg_reg.key_part_2;
            REG_KEY_PART_3:      prdata = cfg_reg.key_part_3;
            REG_NONCE_LOW:       prdata = cfg_reg.nonce_low;
            REG_NONCE_HIGH:      prdata = {32'd0, cfg_reg.nonce_high};
            REG_INITIAL_COUNTER: prdata = {32'd0, cfg_reg.initial_counter};
            default:             prdata = 64'd0;
        endcase
    end

    cc20_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .plain_byte     (plain_byte),
        .end_of_message (end_of_message),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cipher_byte    (cipher_byte)
    );

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for chacha20_stream_cipher_top. Loads key, nonce and
// counter over APB while the core is idle, streams plaintext words through
// the valid/ready channels with random gaps and back-pressure (but for one calm pass), and compares
// every cipher word with a bit-exact ChaCha keystream predictor.
// ----------------------------------------------------------------------------
module tb;
    import cc20_pkg::*;

    localparam int ROUND_COUNT = 20;
    localparam int CYCLE_LIMIT = 1_600_000;

    class cipher_predictor;
        int          rounds;
        cc20_cfg_t   cfg;
        logic [31:0] block_ctr;
        logic [31:0] ks [16];
        logic [31:0] mix [16];
        int          pos;
        bit          held;
        logic [7:0]  expected_cipher [$];
        int          errors;

        function new(int n);
            rounds = n;
            cfg = '0;
            cfg.initial_counter = INITIAL_COUNTER_RESET;
            block_ctr = INITIAL_COUNTER_RESET;
            pos = 0;
            held = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                REG_KEY_PART_0:      cfg.key_part_0 = v;
                REG_KEY_PART_1:      cfg.key_part_1 = v;
                REG_KEY_PART_2:      cfg.key_part_2 = v;
                REG_KEY_PART_3:      cfg.key_part_3 = v;
                REG_NONCE_LOW:       cfg.nonce_low = v;
                REG_NONCE_HIGH:      cfg.nonce_high = v[31:0];
                REG_INITIAL_COUNTER: cfg.initial_counter = v[31:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] rotl(logic [31:0] v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void quarter(int a, int b, int c, int d);
            mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
            mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
            mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
            mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
        endfunction

        function void make_block();
            logic [31:0] init [16];
            init[0]  = SIGMA_0;
            init[1]  = SIGMA_1;
            init[2]  = SIGMA_2;
            init[3]  = SIGMA_3;
            init[4]  = cfg.key_part_0[31:0];
            init[5]  = cfg.key_part_0[63:32];
            init[6]  = cfg.key_part_1[31:0];
            init[7]  = cfg.key_part_1[63:32];
            init[8]  = cfg.key_part_2[31:0];
            init[9]  = cfg.key_part_2[63:32];
            init[10] = cfg.key_part_3[31:0];
            init[11] = cfg.key_part_3[63:32];
            init[12] = block_ctr;
            init[13] = cfg.nonce_low[31:0];
            init[14] = cfg.nonce_low[63:32];
            init[15] = cfg.nonce_high;
            for (int k = 0; k < 16; k++) mix[k] = init[k];
            for (int r = 0; r < rounds; r += 2)
            begin
                quarter(0, 4, 8, 12);
                quarter(1, 5, 9, 13);
                quarter(2, 6, 10, 14);
                quarter(3, 7, 11, 15);
                quarter(0, 5, 10, 15);
                quarter(1, 6, 11, 12);
                quarter(2, 7, 8, 13);
                quarter(3, 4, 9, 14);
            end
            for (int k = 0; k < 16; k++) ks[k] = mix[k] + init[k];
        endfunction

        function void take_plain(logic [7:0] pb, bit eom, bit rs);
            logic [31:0] w;
            if (rs)
            begin
                block_ctr = cfg.initial_counter;
                held = 0;
                pos = 0;
            end
            if (!held)
            begin
                make_block();
                held = 1;
                pos = 0;
            end
            w = ks[pos / 4];
            expected_cipher.push_back(pb ^ w[8 * (pos % 4) +: 8]);
            pos++;
            if (pos >= 64 || eom)
            begin
                held = 0;
                pos = 0;
                block_ctr++;
            end
        endfunction

        function void check_cipher(logic [7:0] got);
            logic [7:0] want;
            if (expected_cipher.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected cipher word %h", got);
            end
            else
            begin
                want = expected_cipher.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("cipher word mismatch: expected %h, got %h", want, got);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic        in_valid = 1'b0;
    logic [7:0]  plain_byte = '0;
    logic        end_of_message = 1'b0;
    logic        restart = 1'b0;
    logic        out_ready = 1'b0;
    wire  [63:0] prdata;
    wire         pready;
    wire         in_ready;
    wire         out_valid;
    wire  [7:0]  cipher_byte;

    bit calm = 1'b0;
    int cycles = 0;
    cipher_predictor pred = new(ROUND_COUNT);

    always #5 clk = ~clk;

    chacha20_stream_cipher_top #(
        .ROUND_COUNT(ROUND_COUNT)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .plain_byte    (plain_byte),
        .end_of_message(end_of_message),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cipher_byte   (cipher_byte)
    );

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) pred.check_cipher(cipher_byte);
        out_ready <= calm || ($urandom_range(99) >= 35);
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] v);
        logic [63:0] want_rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        pred.write_reg(idx, v);
        want_rd = (idx inside {REG_NONCE_HIGH, REG_INITIAL_COUNTER}) ? {32'd0, v[31:0]} : v;
        if (prdata !== want_rd)
        begin
            pred.errors++;
            if (pred.errors <= 10)
                $display("register read mismatch: expected %h, got %h", want_rd, prdata);
        end
    endtask

    // upper half of the 32-bit registers gets junk; only the low word counts
    task automatic set_config(input logic [63:0] k0, input logic [63:0] k1,
                              input logic [63:0] k2, input logic [63:0] k3,
                              input logic [63:0] nl, input logic [31:0] nh,
                              input logic [31:0] ic);
        reg_write(REG_KEY_PART_0, k0);
        reg_write(REG_KEY_PART_1, k1);
        reg_write(REG_KEY_PART_2, k2);
        reg_write(REG_KEY_PART_3, k3);
        reg_write(REG_NONCE_LOW, nl);
        reg_write(REG_NONCE_HIGH, {$urandom(), nh});
        reg_write(REG_INITIAL_COUNTER, {$urandom(), ic});
    endtask

    task automatic random_config(input logic [31:0] ic);
        set_config({$urandom(), $urandom()}, {$urandom(), $urandom()},
                   {$urandom(), $urandom()}, {$urandom(), $urandom()},
                   {$urandom(), $urandom()}, $urandom(), ic);
    endtask

    task automatic send_word(input logic [7:0] b, input bit eom, input bit rs);
        if (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 35);
        end
        in_valid       <= 1'b1;
        plain_byte     <= b;
        end_of_message <= eom;
        restart        <= rs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pred.take_plain(b, eom, rs);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pred.expected_cipher.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // mostly restart..eom messages; some with stray flags
    task automatic run_messages(input int n_items);
        int sent;
        int len;
        bit well;
        bit rs;
        bit eo;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(65, 200) : $urandom_range(1, 70);
            well = ($urandom_range(99) < 80);
            for (int i = 0; i < len; i++)
            begin
                if (well)
                begin
                    rs = (i == 0) && ($urandom_range(3) != 0);
                    eo = (i == len - 1);
                end
                else
                begin
                    rs = ($urandom_range(19) == 0);
                    eo = ($urandom_range(19) == 0);
                end
                send_word(8'($urandom_range(255)), eo, rs);
            end
            sent += len;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key and counter
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hA5, 1'b1, 1'b0);
        send_word(8'h5A, 1'b1, 1'b1);
        drain();

        // standard test key/nonce, ends mid-block
        set_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                   64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                   64'h4a000000_09000000, 32'h0, 32'h1);
        send_word(8'h4c, 1'b0, 1'b1);
        send_word(8'h61, 1'b0, 1'b0);
        send_word(8'h64, 1'b0, 1'b0);
        send_word(8'h69, 1'b1, 1'b0);
        send_word(8'h65, 1'b0, 1'b0);
        send_word(8'h73, 1'b0, 1'b0);
        drain();

        // all ones; held block survives the writes, then counter wrap
        set_config('1, '1, '1, '1, '1, '1, 32'hFFFF_FFFF);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h12, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h34, 1'b0, 1'b1);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            calm = (p == 2);
            case (p)
                3: random_config(32'hFFFF_FFFE);
                4: set_config('0, '0, '0, '0, '0, '0, 32'h0);
                default: random_config($urandom());
            endcase
            run_messages(115);
            drain();
        end
        calm = 1'b0;

        repeat (400) @(posedge clk);
        if (pred.errors == 0 && pred.expected_cipher.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- chacha20_stream_cipher_top.f -----
hdl/cc20_pkg.sv
hdl/cc20_core.sv
hdl/chacha20_stream_cipher_top.sv
bench/tb.sv
